[design/tlca_pkg.sv]
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared types, codes and sizes of the tree LCA / binary lifting engine.
// ----------------------------------------------------------------------------
`default_nettype none
package tlca_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int K_LEVELS   = (LOG_LEVELS < 10) ? LOG_LEVELS : 10;
    localparam int NODE_W     = 10;
    localparam int CNT_W      = 11;
    localparam int EDGE_CAP   = 2 * MAX_NODES;
    localparam int EIDX_W     = $clog2(EDGE_CAP);
    localparam int LINK_W     = 12;
    localparam int TIME_W     = 11;
    localparam int SP_W       = 11;
    localparam int LVL_W      = 4;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_BLD = 2'd1;
    localparam logic [1:0] OP_LCA = 2'd2;
    localparam logic [1:0] OP_KTH = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOBLD = 2'd3;

    localparam logic [4:0] S_INIT = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DISP = 5'd2;
    localparam logic [4:0] S_E0   = 5'd3;
    localparam logic [4:0] S_E1   = 5'd4;
    localparam logic [4:0] S_E2   = 5'd5;
    localparam logic [4:0] S_E3   = 5'd6;
    localparam logic [4:0] S_CLR  = 5'd7;
    localparam logic [4:0] S_ENT0 = 5'd8;
    localparam logic [4:0] S_LV   = 5'd9;
    localparam logic [4:0] S_ENTW = 5'd10;
    localparam logic [4:0] S_TOP  = 5'd11;
    localparam logic [4:0] S_TOP1 = 5'd12;
    localparam logic [4:0] S_EDG  = 5'd13;
    localparam logic [4:0] S_VIS  = 5'd14;
    localparam logic [4:0] S_L0   = 5'd15;
    localparam logic [4:0] S_L1   = 5'd16;
    localparam logic [4:0] S_L2   = 5'd17;
    localparam logic [4:0] S_L3   = 5'd18;
    localparam logic [4:0] S_L4   = 5'd19;
    localparam logic [4:0] S_L5   = 5'd20;
    localparam logic [4:0] S_K0   = 5'd21;
    localparam logic [4:0] S_K1   = 5'd22;
    localparam logic [4:0] S_DONE = 5'd23;

    typedef struct packed {
        logic [1:0]        op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] steps;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] answer_node;
        logic [1:0]        status;
    } t_out;

    typedef logic [LOG_LEVELS-1:0][NODE_W-1:0] t_row;

    typedef struct packed {
        logic [4:0] state;
        logic       accept;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       err;
        logic       cnt_last;
        logic       lvl_top;
        logic       lvl_zero;
        logic       k_last;
        logic       sp_zero;
        logic       edge_end;
        logic       enter_ok;
        logic       found;
    } t_stat;

endpackage
`default_nettype wire

[design/tree_lca_binary_lifting.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Tree query engine: edge store, depth-first build of entry/exit times and a
// binary-lifting ancestor table, LCA and kth-ancestor queries.
// ----------------------------------------------------------------------------
// Add edge links both directions; LCA ends early when one node is the other's
//   ancestor, else lifts level by level; kth ancestor walks all K_LEVELS levels.
// Build: clear of times, ancestors and visited flags, then per node entered one step
//   per ancestor level, per node left a stack read and pop, and per edge link walked
//   a stack read, edge read, stack update and visited check.
// One word in flight at a time; the result strobe lasts one cycle and cannot be
//   stalled. After reset the adjacency heads of all 1024 nodes are cleared
//   with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none
module tree_lca_binary_lifting (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // command channel
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire tlca_pkg::t_in   i_item,
    // result word, one-cycle strobe
    output logic                 o_res_valid,
    output tlca_pkg::t_out       o_res,
    // configuration: index 0 node_count, index 1 root_node
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_index,
    input  wire logic [10:0]     i_cfg_data
);

    tlca_pkg::t_cmd  w_cmd;
    tlca_pkg::t_stat w_stat;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    tlca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid)
    );

    tlca_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_item),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

[design/tlca_datapath.sv]
// ----------------------------------------------------------------------------
// tlca_datapath
// Edge store, walk stack, time and ancestor memories plus work registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tlca_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tlca_pkg::t_cmd      i_cmd,
    input  wire tlca_pkg::t_in       i_item,
    input  wire logic                i_cfg_wr,
    input  wire logic                i_cfg_index,
    input  wire logic [10:0]         i_cfg_data,
    output tlca_pkg::t_stat          o_stat,
    output tlca_pkg::t_out           o_res
);

    localparam int NW = tlca_pkg::NODE_W;
    localparam int LW = tlca_pkg::LINK_W;
    localparam int TW = tlca_pkg::TIME_W;
    localparam int EW = tlca_pkg::EIDX_W;

    // memories
    logic [LW-1:0]    head_mem [tlca_pkg::MAX_NODES];
    logic [NW+LW-1:0] edge_mem [tlca_pkg::EDGE_CAP];
    logic [TW-1:0]    tin_mem  [tlca_pkg::MAX_NODES];
    logic [TW-1:0]    tout_mem [tlca_pkg::MAX_NODES];
    tlca_pkg::t_row   anc_mem  [tlca_pkg::MAX_NODES];
    logic             vis_mem  [tlca_pkg::MAX_NODES];
    logic [NW+LW-1:0] stk_mem  [tlca_pkg::MAX_NODES];

    logic h_we, h_re, e_we, e_re, ti_we, ti_re, to_we, to_re;
    logic a_we, a_re, v_we, v_re, s_we, s_re, v_wdata;
    logic [NW-1:0] h_waddr, h_raddr, ti_waddr, ti_raddr, to_waddr, to_raddr;
    logic [NW-1:0] a_waddr, a_raddr, v_waddr, v_raddr, s_waddr, s_raddr;
    logic [EW-1:0] e_waddr, e_raddr;
    logic [LW-1:0] h_wdata;
    logic [NW+LW-1:0] e_wdata, s_wdata;
    logic [TW-1:0] ti_wdata, to_wdata;
    tlca_pkg::t_row a_wdata;

    logic [LW-1:0]    r_h_rd;
    logic [NW+LW-1:0] r_e_rd, r_s_rd;
    logic [TW-1:0]    r_ti_rd, r_to_rd;
    tlca_pkg::t_row   r_a_rd;
    logic             r_v_rd;

    // control registers
    logic [tlca_pkg::CNT_W-1:0] r_ncount;
    logic [NW-1:0]              r_root;
    logic [LW-1:0]              r_fill;
    logic                       r_built;
    logic [TW-1:0]              r_time;
    logic [tlca_pkg::SP_W-1:0]  r_sp;
    logic [NW-1:0]              r_cnt;

    // work registers
    logic [1:0]                 r_op;
    logic [NW-1:0]              r_a, r_b, r_k, r_u, r_p, r_v, r_w, r_cur, r_ans;
    logic [1:0]                 r_st;
    logic [tlca_pkg::LVL_W-1:0] r_lvl;
    tlca_pkg::t_row             r_row;
    logic [TW-1:0]              r_tin_u, r_tout_u, r_tin_v, r_tout_v;

    logic [tlca_pkg::CNT_W-1:0] n_eff;
    logic                       a_bad, b_bad, root_bad;
    logic [1:0]                 disp_st;
    tlca_pkg::t_row             lv_src;
    logic [NW-1:0]              lv_next, w_sel, u_new, u_k, sp_top, s_node, e_tgt;
    logic [LW-1:0]              s_link, e_next;
    logic                       u_anc_v, v_anc_u, w_anc_v;

    assign n_eff    = (r_ncount > tlca_pkg::CNT_W'(tlca_pkg::MAX_NODES))
                    ? tlca_pkg::CNT_W'(tlca_pkg::MAX_NODES) : r_ncount;
    assign a_bad    = {1'b0, r_a} >= n_eff;
    assign b_bad    = {1'b0, r_b} >= n_eff;
    assign root_bad = {1'b0, r_root} >= n_eff;

    always_comb begin
        disp_st = tlca_pkg::ST_OK;
        case (r_op)
            tlca_pkg::OP_ADD: begin
                if (a_bad || b_bad) disp_st = tlca_pkg::ST_RANGE;
                else if (r_fill > LW'(tlca_pkg::EDGE_CAP - 2)) disp_st = tlca_pkg::ST_FULL;
            end
            tlca_pkg::OP_BLD: begin
                if (root_bad) disp_st = tlca_pkg::ST_RANGE;
            end
            tlca_pkg::OP_LCA: begin
                if (a_bad || b_bad) disp_st = tlca_pkg::ST_RANGE;
                else if (!r_built) disp_st = tlca_pkg::ST_NOBLD;
            end
            default: begin
                if (a_bad) disp_st = tlca_pkg::ST_RANGE;
                else if (!r_built) disp_st = tlca_pkg::ST_NOBLD;
            end
        endcase
    end

    // root refers to its own row while that row is still being built
    assign lv_src  = (r_cur == r_u) ? r_row : r_a_rd;
    assign lv_next = lv_src[r_lvl - tlca_pkg::LVL_W'(1)];
    assign w_sel   = r_a_rd[r_lvl];
    assign sp_top  = NW'(r_sp - tlca_pkg::SP_W'(1));
    assign s_node  = r_s_rd[NW+LW-1:LW];
    assign s_link  = r_s_rd[LW-1:0];
    assign e_tgt   = r_e_rd[NW+LW-1:LW];
    assign e_next  = r_e_rd[LW-1:0];
    assign u_anc_v = (r_tin_u <= r_ti_rd) && (r_tout_u >= r_to_rd);
    assign v_anc_u = (r_ti_rd <= r_tin_u) && (r_to_rd >= r_tout_u);
    assign w_anc_v = (r_ti_rd <= r_tin_v) && (r_to_rd >= r_tout_v);
    assign u_new   = w_anc_v ? r_u : r_w;
    assign u_k     = r_k[r_lvl] ? r_a_rd[r_lvl] : r_u;

    always_comb begin
        h_we = 1'b0; h_re = 1'b0; e_we = 1'b0; e_re = 1'b0;
        ti_we = 1'b0; ti_re = 1'b0; to_we = 1'b0; to_re = 1'b0;
        a_we = 1'b0; a_re = 1'b0; v_we = 1'b0; v_re = 1'b0;
        s_we = 1'b0; s_re = 1'b0;
        h_waddr = r_a; h_raddr = r_a; h_wdata = r_fill;
        e_waddr = r_fill[EW-1:0]; e_raddr = s_link[EW-1:0]; e_wdata = {r_b, r_h_rd};
        ti_waddr = r_cnt; ti_raddr = r_a; ti_wdata = '0;
        to_waddr = r_cnt; to_raddr = r_a; to_wdata = '0;
        a_waddr = r_cnt; a_raddr = r_u; a_wdata = '0;
        v_waddr = r_cnt; v_raddr = e_tgt; v_wdata = 1'b0;
        s_waddr = r_sp[NW-1:0]; s_raddr = sp_top; s_wdata = {r_u, r_h_rd};
        case (i_cmd.state)
            tlca_pkg::S_INIT: begin
                h_we = 1'b1; h_waddr = r_cnt; h_wdata = LW'(tlca_pkg::EDGE_CAP);
            end
            tlca_pkg::S_E0: h_re = 1'b1;
            tlca_pkg::S_E1: begin
                e_we = 1'b1; h_we = 1'b1;
            end
            tlca_pkg::S_E2: begin
                h_re = 1'b1; h_raddr = r_b;
            end
            tlca_pkg::S_E3: begin
                e_we = 1'b1; e_wdata = {r_a, r_h_rd};
                h_we = 1'b1; h_waddr = r_b;
            end
            tlca_pkg::S_CLR: begin
                ti_we = 1'b1; to_we = 1'b1; a_we = 1'b1; v_we = 1'b1;
            end
            tlca_pkg::S_ENT0: begin
                ti_we = 1'b1; ti_waddr = r_u; ti_wdata = r_time;
                v_we = 1'b1; v_waddr = r_u; v_wdata = 1'b1;
                h_re = 1'b1; h_raddr = r_u;
                a_re = 1'b1; a_raddr = r_p;
            end
            tlca_pkg::S_LV: begin
                a_re = 1'b1; a_raddr = lv_next;
            end
            tlca_pkg::S_ENTW: begin
                a_we = 1'b1; a_waddr = r_u; a_wdata = r_row;
                s_we = 1'b1;
            end
            tlca_pkg::S_TOP: s_re = 1'b1;
            tlca_pkg::S_TOP1: begin
                if (s_link >= LW'(tlca_pkg::EDGE_CAP)) begin
                    to_we = 1'b1; to_waddr = s_node; to_wdata = r_time;
                end else begin
                    e_re = 1'b1;
                end
            end
            tlca_pkg::S_EDG: begin
                s_we = 1'b1; s_waddr = sp_top; s_wdata = {r_u, e_next};
                v_re = 1'b1;
            end
            tlca_pkg::S_L0: begin
                ti_re = 1'b1; to_re = 1'b1;
            end
            tlca_pkg::S_L1: begin
                ti_re = 1'b1; to_re = 1'b1; ti_raddr = r_b; to_raddr = r_b;
            end
            tlca_pkg::S_L2: a_re = 1'b1;
            tlca_pkg::S_L3: begin
                ti_re = 1'b1; to_re = 1'b1; ti_raddr = w_sel; to_raddr = w_sel;
            end
            tlca_pkg::S_L4: begin
                a_re = 1'b1; a_raddr = u_new;
            end
            tlca_pkg::S_K0: a_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) head_mem[h_waddr] <= h_wdata;
        if (h_re) r_h_rd <= head_mem[h_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (e_we) edge_mem[e_waddr] <= e_wdata;
        if (e_re) r_e_rd <= edge_mem[e_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (ti_we) tin_mem[ti_waddr] <= ti_wdata;
        if (ti_re) r_ti_rd <= tin_mem[ti_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (to_we) tout_mem[to_waddr] <= to_wdata;
        if (to_re) r_to_rd <= tout_mem[to_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (a_we) anc_mem[a_waddr] <= a_wdata;
        if (a_re) r_a_rd <= anc_mem[a_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (v_we) vis_mem[v_waddr] <= v_wdata;
        if (v_re) r_v_rd <= vis_mem[v_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (s_we) stk_mem[s_waddr] <= s_wdata;
        if (s_re) r_s_rd <= stk_mem[s_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncount <= tlca_pkg::CNT_W'(1024);
            r_root   <= '0;
            r_fill   <= '0;
            r_built  <= 1'b0;
            r_time   <= '0;
            r_sp     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_wr) begin
                if (i_cfg_index) r_root <= i_cfg_data[NW-1:0];
                else r_ncount <= i_cfg_data;
            end
            case (i_cmd.state)
                tlca_pkg::S_INIT, tlca_pkg::S_CLR: r_cnt <= r_cnt + NW'(1);
                tlca_pkg::S_DISP: r_cnt <= '0;
                tlca_pkg::S_E1, tlca_pkg::S_E3: r_fill <= r_fill + LW'(1);
                tlca_pkg::S_ENT0: r_time <= r_time + TW'(1);
                tlca_pkg::S_ENTW: r_sp <= r_sp + tlca_pkg::SP_W'(1);
                tlca_pkg::S_TOP: begin
                    if (r_sp == '0) r_built <= 1'b1;
                end
                tlca_pkg::S_TOP1: begin
                    if (s_link >= LW'(tlca_pkg::EDGE_CAP)) begin
                        r_time <= r_time + TW'(1);
                        r_sp   <= r_sp - tlca_pkg::SP_W'(1);
                    end
                end
                default: ;
            endcase
            if (i_cmd.state == tlca_pkg::S_CLR && r_cnt == '1) begin
                r_time <= '0;
                r_sp   <= '0;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_item.op;
            r_a  <= i_item.node_a;
            r_b  <= i_item.node_b;
            r_k  <= i_item.steps;
        end
        case (i_cmd.state)
            tlca_pkg::S_DISP: begin
                r_st  <= disp_st;
                r_ans <= '0;
                r_u   <= r_a;
                r_lvl <= (r_op == tlca_pkg::OP_KTH) ? '0
                       : tlca_pkg::LVL_W'(tlca_pkg::LOG_LEVELS - 1);
            end
            tlca_pkg::S_CLR: begin
                r_u <= r_root;
                r_p <= r_root;
            end
            tlca_pkg::S_ENT0: begin
                // level 0 is the parent, upper levels start cleared
                r_row <= {{((tlca_pkg::LOG_LEVELS - 1) * NW){1'b0}}, r_p};
                r_cur <= r_p;
                r_lvl <= tlca_pkg::LVL_W'(1);
            end
            tlca_pkg::S_LV: begin
                r_row[r_lvl] <= lv_next;
                r_cur        <= lv_next;
                r_lvl        <= r_lvl + tlca_pkg::LVL_W'(1);
            end
            tlca_pkg::S_TOP1: r_u <= s_node;
            tlca_pkg::S_EDG:  r_v <= e_tgt;
            tlca_pkg::S_VIS: begin
                r_p <= r_u;
                r_u <= r_v;
            end
            tlca_pkg::S_L1: begin
                r_tin_u  <= r_ti_rd;
                r_tout_u <= r_to_rd;
            end
            tlca_pkg::S_L2: begin
                r_tin_v  <= r_ti_rd;
                r_tout_v <= r_to_rd;
                if (u_anc_v) r_ans <= r_a;
                else if (v_anc_u) r_ans <= r_b;
            end
            tlca_pkg::S_L3: r_w <= w_sel;
            tlca_pkg::S_L4: begin
                r_u   <= u_new;
                r_lvl <= r_lvl - tlca_pkg::LVL_W'(1);
            end
            tlca_pkg::S_L5: r_ans <= r_a_rd[0];
            tlca_pkg::S_K1: begin
                r_u   <= u_k;
                r_ans <= u_k;
                r_lvl <= r_lvl + tlca_pkg::LVL_W'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.err      = disp_st != tlca_pkg::ST_OK;
        o_stat.cnt_last = r_cnt == '1;
        o_stat.lvl_top  = r_lvl == tlca_pkg::LVL_W'(tlca_pkg::LOG_LEVELS - 1);
        o_stat.lvl_zero = r_lvl == '0;
        o_stat.k_last   = r_lvl == tlca_pkg::LVL_W'(tlca_pkg::K_LEVELS - 1);
        o_stat.sp_zero  = r_sp == '0;
        o_stat.edge_end = s_link >= LW'(tlca_pkg::EDGE_CAP);
        o_stat.enter_ok = ({1'b0, r_v} < n_eff) && !r_v_rd;
        o_stat.found    = u_anc_v || v_anc_u;
        o_res.answer_node = r_ans;
        o_res.status      = r_st;
    end

endmodule
`default_nettype wire

[design/tlca_ctrl.sv]
// ----------------------------------------------------------------------------
// tlca_ctrl
// Sequencer: one state per datapath step; drives busy and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module tlca_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire tlca_pkg::t_stat i_stat,
    output tlca_pkg::t_cmd       o_cmd,
    output logic                 o_busy,
    output logic                 o_res_valid
);

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlca_pkg::S_INIT: if (i_stat.cnt_last) n_state = tlca_pkg::S_IDLE;
            tlca_pkg::S_IDLE: if (i_start) n_state = tlca_pkg::S_DISP;
            tlca_pkg::S_DISP: begin
                if (i_stat.err) n_state = tlca_pkg::S_DONE;
                else begin
                    case (i_stat.op)
                        tlca_pkg::OP_ADD: n_state = tlca_pkg::S_E0;
                        tlca_pkg::OP_BLD: n_state = tlca_pkg::S_CLR;
                        tlca_pkg::OP_LCA: n_state = tlca_pkg::S_L0;
                        default:          n_state = tlca_pkg::S_K0;
                    endcase
                end
            end
            tlca_pkg::S_E0: n_state = tlca_pkg::S_E1;
            tlca_pkg::S_E1: n_state = tlca_pkg::S_E2;
            tlca_pkg::S_E2: n_state = tlca_pkg::S_E3;
            tlca_pkg::S_E3: n_state = tlca_pkg::S_DONE;
            tlca_pkg::S_CLR: if (i_stat.cnt_last) n_state = tlca_pkg::S_ENT0;
            tlca_pkg::S_ENT0: n_state = (tlca_pkg::LOG_LEVELS > 1) ? tlca_pkg::S_LV
                                                                   : tlca_pkg::S_ENTW;
            tlca_pkg::S_LV: if (i_stat.lvl_top) n_state = tlca_pkg::S_ENTW;
            tlca_pkg::S_ENTW: n_state = tlca_pkg::S_TOP;
            tlca_pkg::S_TOP: n_state = i_stat.sp_zero ? tlca_pkg::S_DONE : tlca_pkg::S_TOP1;
            tlca_pkg::S_TOP1: n_state = i_stat.edge_end ? tlca_pkg::S_TOP : tlca_pkg::S_EDG;
            tlca_pkg::S_EDG: n_state = tlca_pkg::S_VIS;
            tlca_pkg::S_VIS: n_state = i_stat.enter_ok ? tlca_pkg::S_ENT0 : tlca_pkg::S_TOP;
            tlca_pkg::S_L0: n_state = tlca_pkg::S_L1;
            tlca_pkg::S_L1: n_state = tlca_pkg::S_L2;
            tlca_pkg::S_L2: n_state = i_stat.found ? tlca_pkg::S_DONE : tlca_pkg::S_L3;
            tlca_pkg::S_L3: n_state = tlca_pkg::S_L4;
            tlca_pkg::S_L4: n_state = i_stat.lvl_zero ? tlca_pkg::S_L5 : tlca_pkg::S_L3;
            tlca_pkg::S_L5: n_state = tlca_pkg::S_DONE;
            tlca_pkg::S_K0: n_state = tlca_pkg::S_K1;
            tlca_pkg::S_K1: if (i_stat.k_last) n_state = tlca_pkg::S_DONE;
                            else n_state = tlca_pkg::S_K0;
            tlca_pkg::S_DONE: n_state = tlca_pkg::S_IDLE;
            default: n_state = tlca_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tlca_pkg::S_INIT;
        else r_state <= n_state;
    end

    assign o_cmd.state  = r_state;
    assign o_cmd.accept = i_start && (r_state == tlca_pkg::S_IDLE);
    assign o_busy       = r_state != tlca_pkg::S_IDLE;
    assign o_res_valid  = r_state == tlca_pkg::S_DONE;

endmodule
`default_nettype wire
